// File: sv/frustum_aabb_cull_unit_macros.svh
`ifndef FRUSTUM_AABB_CULL_UNIT_MACROS_SVH
`define FRUSTUM_AABB_CULL_UNIT_MACROS_SVH

// clocked on clk, held off while rst is high
`define FAC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`define FAC_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// File: sv/fac_pkg.sv
`timescale 1ns / 1ps

package fac_pkg;

  localparam int COORD_WIDTH_DEF      = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int ID_WIDTH_DEF         = 16;

  localparam int NUM_PLANES      = 6;
  localparam int PLANE_WIDTH     = 64;
  localparam int CFG_INDEX_WIDTH = 3;

endpackage

// File: sv/fac_box_if.sv
`timescale 1ns / 1ps

interface fac_box_if import fac_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [ID_WIDTH-1:0]           item_id;
  logic signed [COORD_WIDTH-1:0] min_x;
  logic signed [COORD_WIDTH-1:0] min_y;
  logic signed [COORD_WIDTH-1:0] min_z;
  logic signed [COORD_WIDTH-1:0] max_x;
  logic signed [COORD_WIDTH-1:0] max_y;
  logic signed [COORD_WIDTH-1:0] max_z;
  logic                          batch_last;

  modport source (
    output valid, item_id, min_x, min_y, min_z, max_x, max_y, max_z, batch_last,
    input  ready
  );

  modport sink (
    input  valid, item_id, min_x, min_y, min_z, max_x, max_y, max_z, batch_last,
    output ready
  );
endinterface

// File: sv/fac_hit_if.sv
`timescale 1ns / 1ps

interface fac_hit_if import fac_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] hit_id;
  logic                visible;
  logic                batch_done;

  modport source (output valid, hit_id, visible, batch_done, input ready);
  modport sink   (input valid, hit_id, visible, batch_done, output ready);
endinterface

// File: sv/fac_cell.sv
`timescale 1ns / 1ps

`include "frustum_aabb_cull_unit_macros.svh"

module fac_cell import fac_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
  parameter int ID_WIDTH         = ID_WIDTH_DEF,
  parameter int PLANE_INDEX      = 0,
  localparam int BW              = ID_WIDTH + 6 * COORD_WIDTH + 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [PLANE_WIDTH-1:0]     cfg_data,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [BW-1:0]              up_data,
  output logic                       down_valid,
  input  logic                       down_ready,
  output logic [BW-1:0]              down_data
);

  localparam int NW  = NORMAL_FRAC_BITS + 2;
  localparam int CW  = COORD_WIDTH;
  localparam int PRW = NW + CW;
  localparam int SW  = PRW + 2;
  localparam int FW  = 3 * NW + CW;
  localparam int PW  = (FW > PLANE_WIDTH) ? FW : PLANE_WIDTH;

  // payload: {id, min z/y/x, max z/y/x, last, visible}
  localparam int HI_BASE = 2;
  localparam int LO_BASE = 2 + 3 * CW;

  logic [PLANE_WIDTH-1:0] plane;
  logic [PW-1:0]          plane_ext;

  logic signed [NW-1:0]  nrm [3];
  logic signed [CW-1:0]  crd [3];
  logic signed [PRW-1:0] prod_next [3];
  logic signed [PRW-1:0] prod [3];
  logic signed [CW-1:0]  offset;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  offset_shift;
  logic                  outside;

  logic          a_valid;
  logic [BW-1:0] a_data;
  logic          a_ready;
  logic          b_valid;
  logic [BW-1:0] b_data;
  logic          b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (cfg_we && cfg_index == CFG_INDEX_WIDTH'(PLANE_INDEX)) begin
      plane <= cfg_data;
    end
  end

  assign plane_ext = PW'(plane);
  assign offset    = $signed(plane_ext[3*NW +: CW]);

  // p-vertex select and per-axis products
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nrm[a] = $signed(plane_ext[a*NW +: NW]);
      crd[a] = nrm[a][NW-1] ? $signed(up_data[LO_BASE + a*CW +: CW])
                            : $signed(up_data[HI_BASE + a*CW +: CW]);
      prod_next[a] = PRW'(nrm[a]) * PRW'(crd[a]);
    end
  end

  assign sum          = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
  assign offset_shift = SW'(offset) <<< NORMAL_FRAC_BITS;
  assign outside      = sum < offset_shift;

  assign b_ready  = !b_valid || down_ready;
  assign a_ready  = !a_valid || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && a_ready) begin
      a_data <= up_data;
      for (int a = 0; a < 3; a++) begin
        prod[a] <= prod_next[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      b_data <= {a_data[BW-1:1], a_data[0] & !outside};
    end
  end

  assign down_valid = b_valid;
  assign down_data  = b_data;

  `FAC_ASSERT_NEXT(a_cull_sticky, a_valid && b_ready && !a_data[0], !b_data[0],
                   "visible flag came back")
  `FAC_ASSERT_NEXT(a_box_kept, a_valid && b_ready,
                   b_data[BW-1:1] == $past(a_data[BW-1:1]), "box fields altered in cell")
  `FAC_ASSERT_NEXT(a_plane_write, cfg_we && cfg_index == CFG_INDEX_WIDTH'(PLANE_INDEX),
                   plane == $past(cfg_data), "plane write lost")

endmodule

// File: sv/frustum_aabb_cull_unit.sv
// channel | dir | handshake         | payload
// box     | in  | valid/ready       | item_id, min_x/y/z, max_x/y/z, batch_last
// hit     | out | valid/ready       | hit_id, visible, batch_done
// cfg     | in  | cfg_we, no ready  | cfg_index (plane 0..5), cfg_data (64b)
//
// One request per cycle sustained while hit.ready stays high; two stages in
// each of six plane cells (products, then sum and compare).
// Synchronous reset clears all stage valids and zeroes the six planes.
// Each stage has its own valid; ready ripples back from the output, so
// empty stages keep filling while a result waits at the output.
`timescale 1ns / 1ps

module frustum_aabb_cull_unit import fac_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
  parameter int ID_WIDTH         = ID_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  fac_box_if.sink                    box,
  fac_hit_if.source                  hit,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [PLANE_WIDTH-1:0]     cfg_data
);

  localparam int BW = ID_WIDTH + 6 * COORD_WIDTH + 2;

  logic          chain_valid [NUM_PLANES+1];
  logic          chain_ready [NUM_PLANES+1];
  logic [BW-1:0] chain_data  [NUM_PLANES+1];

  assign chain_valid[0] = box.valid;
  assign box.ready      = chain_ready[0];
  assign chain_data[0]  = {box.item_id, box.min_z, box.min_y, box.min_x,
                           box.max_z, box.max_y, box.max_x, box.batch_last, 1'b1};

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    fac_cell #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
      .ID_WIDTH         (ID_WIDTH),
      .PLANE_INDEX      (p)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cfg_we     (cfg_we),
      .cfg_index  (cfg_index),
      .cfg_data   (cfg_data),
      .up_valid   (chain_valid[p]),
      .up_ready   (chain_ready[p]),
      .up_data    (chain_data[p]),
      .down_valid (chain_valid[p+1]),
      .down_ready (chain_ready[p+1]),
      .down_data  (chain_data[p+1])
    );
  end

  assign hit.valid               = chain_valid[NUM_PLANES];
  assign chain_ready[NUM_PLANES] = hit.ready;
  assign hit.hit_id              = chain_data[NUM_PLANES][BW-1 -: ID_WIDTH];
  assign hit.visible             = chain_data[NUM_PLANES][0];
  assign hit.batch_done          = chain_data[NUM_PLANES][1];

endmodule
